// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit free-list allocator: sizes, request/response
// structs, status codes, controller states and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package ffa_pkg;

  // Table and heap geometry
  localparam int unsigned FREE_SLOTS   = 64;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned IDX_W        = $clog2(FREE_SLOTS);
  localparam int unsigned CNT_W        = $clog2(FREE_SLOTS + 1);
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned SIZE_W       = 24;
  localparam int unsigned NEED_W       = SIZE_W + 1;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(1);

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = '0;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = '1;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffa_op_e;

  typedef enum logic [1:0] {
    RSP_OK   = 2'd0,
    RSP_OOM  = 2'd1,
    RSP_FULL = 2'd2,
    RSP_NULL = 2'd3
  } ffa_status_e;

  typedef struct packed {
    ffa_op_e           opcode;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
    logic [SIZE_W-1:0] free_size;
  } ffa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [SIZE_W-1:0] granted_size;
    ffa_status_e       status;
  } ffa_rsp_t;

  // One free-table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } ffa_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_BUMP,
    S_RESP
  } ffa_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic free_op;
    logic scan;
    logic shift;
    logic bump;
    logic emit;
  } ffa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic oversize;
    logic table_empty;
    logic hit;
    logic scan_miss;
    logic shift_done;
    logic out_ready;
  } ffa_stat_t;

  // Round a request up to the alignment; zero becomes one aligned unit
  function automatic logic [NEED_W-1:0] round_need(input logic [SIZE_W-1:0] req);
    logic [NEED_W-1:0] sum;
    sum = NEED_W'(req) + NEED_W'(ALIGN_BYTES - 1);
    if (req == '0) begin
      return NEED_W'(ALIGN_BYTES);
    end
    return sum & ~NEED_W'(ALIGN_BYTES - 1);
  endfunction

endpackage

// ----- rtl/first_fit_free_list_allocator_core.sv -----
// Top level of the first-fit free-list allocator: joins controller and
// datapath. Depends on ffa_pkg, ffa_ctrl, ffa_dp (and ffa_ram below it).
//
//   Port group  Direction  Handshake            Payload
//   in_*        input      in_valid_i/in_stall_o   ffa_req_t  (request)
//   out_*       output     out_valid_o/out_stall_i ffa_rsp_t  (response)
//   cfg_*       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// A free or an oversized allocate goes from decode straight to the response
// state, an allocate on an empty table through the heap bump. Otherwise the
// walk reads the table entries newest first, one per cycle behind the
// registered RAM read: a miss goes on to the heap bump, and a hit k entries
// below the newest to compaction, where the k newer entries move down one per
// cycle. After the response the engine returns to idle and accepts another
// request there; one request is in flight at a time, and it is accepted while
// the last response still sits in the output register. Reset clears the free
// count and the heap top valid bit; the table RAM needs no clearing pass. A
// stalled response holds the engine in S_RESP until the output register drains.
`timescale 1ns / 1ps

module first_fit_free_list_allocator_core import ffa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ffa_req_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ffa_rsp_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ffa_cmd_t  cmd;
  ffa_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ----- rtl/ffa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ffa_ctrl.sv -----
// Controller state machine of the allocator: sequences decode, table scan,
// table compaction, heap bump and response. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ffa_stat_t stat_i,
  output ffa_cmd_t  cmd_o
);

  ffa_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat_i.is_free) begin
          state_d = S_RESP;
        end else if (stat_i.oversize) begin
          state_d = S_RESP;
        end else if (stat_i.table_empty) begin
          state_d = S_BUMP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat_i.hit) begin
          state_d = S_SHIFT;
        end else if (stat_i.scan_miss) begin
          state_d = S_BUMP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = S_RESP;
        end
      end
      S_BUMP: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.free_op = stat_i.is_free;
        cmd_o.prep    = !stat_i.is_free;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
      end
      S_BUMP: begin
        cmd_o.bump = 1'b1;
      end
      S_RESP: begin
        cmd_o.emit = stat_i.out_ready;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- rtl/ffa_dp.sv -----
// Datapath of the allocator: request register, free table RAM with scan and
// compaction pointers, heap top, config registers and output register.
// Depends on ffa_pkg and ffa_ram.
`timescale 1ns / 1ps

module ffa_dp import ffa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ffa_req_t              in_data_i,
  output ffa_rsp_t              out_data_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ffa_cmd_t              cmd_i,
  output ffa_stat_t             stat_o
);

  localparam int unsigned TOP_W = ADDR_W + 1;

  ffa_req_t          item_q;
  logic [NEED_W-1:0] need_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] base_q, limit_q, top_q;
  logic              top_valid_q;
  ffa_rsp_t          res_q, out_q;
  logic              out_valid_q;

  // Scan pipeline
  logic [IDX_W-1:0]  rd_ptr_q;
  logic              issue_left_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;

  // Compaction pipeline
  logic [CNT_W-1:0]  sh_rd_q;
  logic              sh_pend_q;
  logic [IDX_W-1:0]  wr_idx_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  ffa_entry_t        ram_wdata, ram_rdata;

  logic [NEED_W-1:0] need_c;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  sh_rd_m1;
  logic              hit;
  logic              sh_issue;
  logic              table_full;
  logic [ADDR_W-1:0] top_eff;
  logic [TOP_W-1:0]  new_top;
  logic [ADDR_W-1:0] user_addr;

  assign need_c     = round_need(item_q.req_size);
  assign cnt_m1     = count_q - CNT_W'(1);
  assign sh_rd_m1   = sh_rd_q - CNT_W'(1);
  assign hit        = cmp_vld_q && (ram_rdata.size >= need_q[SIZE_W-1:0]);
  assign sh_issue   = (sh_rd_q <= count_q);
  assign table_full = (count_q == CNT_W'(FREE_SLOTS));
  assign top_eff    = top_valid_q ? top_q : base_q;
  assign new_top    = TOP_W'(top_eff) + TOP_W'(need_q) + TOP_W'(HEADER_BYTES);
  assign user_addr  = top_eff + ADDR_W'(HEADER_BYTES);

  // Status to the controller
  assign stat_o.is_free     = (item_q.opcode == OP_FREE);
  assign stat_o.oversize    = need_c[NEED_W-1];
  assign stat_o.table_empty = (count_q == '0);
  assign stat_o.hit         = hit;
  assign stat_o.scan_miss   = cmp_vld_q && (cmp_idx_q == '0) && !hit;
  assign stat_o.shift_done  = !sh_pend_q && !sh_issue;
  assign stat_o.out_ready   = !out_valid_q || !out_stall_i;

  // Free table port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx_q;
    ram_wdata = ram_rdata;
    ram_raddr = rd_ptr_q;
    priority if (cmd_i.free_op) begin
      ram_we          = (item_q.block_addr != '0) && !table_full;
      ram_waddr       = count_q[IDX_W-1:0];
      ram_wdata.addr  = item_q.block_addr;
      ram_wdata.size  = item_q.free_size;
    end else if (cmd_i.shift) begin
      ram_we    = sh_pend_q;
      ram_raddr = sh_rd_q[IDX_W-1:0];
    end else begin
      ram_we = 1'b0;
    end
  end

  ffa_ram #(
    .WIDTH ($bits(ffa_entry_t)),
    .DEPTH (FREE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Capture the request and track scan / compaction pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.prep) begin
      need_q       <= need_c;
      rd_ptr_q     <= cnt_m1[IDX_W-1:0];
      issue_left_q <= 1'b1;
      cmp_vld_q    <= 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_q <= issue_left_q;
      cmp_idx_q <= rd_ptr_q;
      if (issue_left_q) begin
        if (rd_ptr_q == '0) begin
          issue_left_q <= 1'b0;
        end else begin
          rd_ptr_q <= rd_ptr_q - IDX_W'(1);
        end
      end
      if (hit) begin
        sh_rd_q   <= CNT_W'(cmp_idx_q) + CNT_W'(1);
        sh_pend_q <= 1'b0;
      end
    end else if (cmd_i.shift) begin
      sh_pend_q <= sh_issue;
      if (sh_issue) begin
        wr_idx_q <= sh_rd_m1[IDX_W-1:0];
        sh_rd_q  <= sh_rd_q + CNT_W'(1);
      end
    end
  end

  // Build the response
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.free_op) begin
      res_q.result_addr  <= '0;
      res_q.granted_size <= '0;
      priority if (item_q.block_addr == '0) begin
        res_q.status <= RSP_NULL;
      end else if (table_full) begin
        res_q.status <= RSP_FULL;
      end else begin
        res_q.status <= RSP_OK;
      end
    end else if (cmd_i.prep) begin
      res_q.result_addr  <= '0;
      res_q.granted_size <= '0;
      res_q.status       <= RSP_OOM;
    end else if (cmd_i.scan && hit) begin
      res_q.result_addr  <= ram_rdata.addr;
      res_q.granted_size <= ram_rdata.size;
      res_q.status       <= RSP_OK;
    end else if (cmd_i.bump) begin
      if (new_top > TOP_W'(limit_q)) begin
        res_q.result_addr  <= '0;
        res_q.granted_size <= '0;
        res_q.status       <= RSP_OOM;
      end else begin
        res_q.result_addr  <= user_addr;
        res_q.granted_size <= need_q[SIZE_W-1:0];
        res_q.status       <= RSP_OK;
      end
    end else begin
      res_q <= res_q;
    end
  end

  // Heap top: load from the base on first bump, advance on success
  always_ff @(posedge clk_i) begin
    if (cmd_i.bump) begin
      if (new_top > TOP_W'(limit_q)) begin
        top_q <= top_eff;
      end else begin
        top_q <= new_top[ADDR_W-1:0];
      end
    end
  end

  // Control registers: fill count, top valid, config, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      top_valid_q <= 1'b0;
      base_q      <= HEAP_BASE_RST;
      limit_q     <= HEAP_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.free_op && (item_q.block_addr != '0) && !table_full) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.scan && hit) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.bump) begin
        top_valid_q <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEAP_BASE:  base_q  <= cfg_data_i[ADDR_W-1:0];
          CFG_HEAP_LIMIT: limit_q <= cfg_data_i[ADDR_W-1:0];
          default:        base_q  <= base_q;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for first_fit_free_list_allocator_core: directed and
// random allocate/free requests checked against a behavioral allocator model.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;
  import ffa_pkg::*;

  localparam int unsigned ALIGN_MASK   = 7;
  localparam int unsigned WATCHDOG_MAX = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUEUE_AHEAD  = 4;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  ffa_req_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  ffa_rsp_t              out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_HEAP_BASE;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  first_fit_free_list_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  // Allocator model state
  logic [ADDR_W-1:0] base_reg  = HEAP_BASE_RST;
  logic [ADDR_W-1:0] limit_reg = HEAP_LIMIT_RST;
  logic [ADDR_W-1:0] heap_top  = '0;
  logic              top_loaded = 1'b0;
  ffa_entry_t        free_tbl[$];

  ffa_req_t   pending[$];
  ffa_rsp_t   awaited_rsp[$];
  ffa_entry_t live_blocks[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        press_on      = 1'b0;
  logic        press_done    = 1'b0;
  int unsigned hold_left     = 0;
  logic        in_took       = 1'b0;
  int unsigned quiet_cycles  = 0;

  int unsigned errs = 0;
  int unsigned n_alloc = 0, n_free = 0, n_reuse = 0;
  int unsigned n_oom = 0, n_full = 0, n_null = 0, n_cfg = 0, n_rsp = 0;

  // Serve one request on the model and return the response it owes
  function automatic ffa_rsp_t serve_request(input ffa_req_t r);
    ffa_rsp_t          ans;
    logic [NEED_W-1:0] need;
    logic [ADDR_W:0]   need_w;
    logic [ADDR_W:0]   next_top;
    int                k;
    ans = '0;
    ans.status = RSP_OK;
    if (r.opcode == OP_FREE) begin
      n_free++;
      if (r.block_addr == '0) begin
        ans.status = RSP_NULL;
        n_null++;
      end else if (free_tbl.size() >= FREE_SLOTS) begin
        ans.status = RSP_FULL;
        n_full++;
      end else begin
        free_tbl.push_back('{addr: r.block_addr, size: r.free_size});
      end
      return ans;
    end
    n_alloc++;
    if (r.req_size == '0) begin
      need = NEED_W'(ALIGN_MASK + 1);
    end else begin
      need = (NEED_W'(r.req_size) + NEED_W'(ALIGN_MASK)) & ~NEED_W'(ALIGN_MASK);
    end
    // Oversized after rounding: no scan, no bump
    if (need[SIZE_W]) begin
      ans.status = RSP_OOM;
      n_oom++;
      return ans;
    end
    // First fit, newest entry first
    for (k = free_tbl.size() - 1; k >= 0; k--) begin
      if (free_tbl[k].size >= need[SIZE_W-1:0]) begin
        ans.result_addr  = free_tbl[k].addr;
        ans.granted_size = free_tbl[k].size;
        free_tbl.delete(k);
        n_reuse++;
        return ans;
      end
    end
    if (!top_loaded) begin
      heap_top   = base_reg;
      top_loaded = 1'b1;
    end
    need_w   = (ADDR_W + 1)'(need);
    next_top = {1'b0, heap_top} + need_w + (ADDR_W + 1)'(HEADER_BYTES);
    if (next_top > {1'b0, limit_reg}) begin
      ans.status = RSP_OOM;
      n_oom++;
      return ans;
    end
    ans.result_addr  = heap_top + ADDR_W'(HEADER_BYTES);
    ans.granted_size = need[SIZE_W-1:0];
    heap_top         = next_top[ADDR_W-1:0];
    return ans;
  endfunction

  function automatic ffa_req_t mk_req(input ffa_op_e op, input logic [SIZE_W-1:0] rq,
                                      input logic [ADDR_W-1:0] ad,
                                      input logic [SIZE_W-1:0] fs);
    ffa_req_t r;
    r.opcode     = op;
    r.req_size   = rq;
    r.block_addr = ad;
    r.free_size  = fs;
    return r;
  endfunction

  // Mostly frees of granted blocks and small allocations, some noise
  function automatic ffa_req_t random_request();
    ffa_req_t    r;
    ffa_entry_t  e;
    int unsigned p;
    int unsigned idx;
    r = mk_req(OP_ALLOC, SIZE_W'($urandom), $urandom, SIZE_W'($urandom));
    p = $urandom_range(99, 0);
    if (p < 55) begin
      p = $urandom_range(99, 0);
      if (p < 3) begin
        r.req_size = SIZE_W'($urandom);
      end else if (p < 15) begin
        r.req_size = SIZE_W'($urandom_range(65535, 513));
      end else begin
        r.req_size = SIZE_W'($urandom_range(512, 0));
      end
    end else begin
      r.opcode = OP_FREE;
      p = $urandom_range(99, 0);
      if (p < 65 && live_blocks.size() != 0) begin
        idx = $urandom_range(live_blocks.size() - 1, 0);
        e   = live_blocks[idx];
        live_blocks.delete(idx);
        r.block_addr = e.addr;
        r.free_size  = e.size;
      end else if (p < 90) begin
        if ($urandom_range(9, 0) != 0) begin
          r.free_size = SIZE_W'($urandom_range(1024, 0));
        end
      end else begin
        r.block_addr = '0;
      end
    end
    return r;
  endfunction

  task automatic offer(input ffa_req_t r);
    while (pending.size() >= QUEUE_AHEAD) @(posedge clk_i);
    pending.push_back(r);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) offer(random_request());
  endtask

  // Wait until every request is answered, then let the engine settle
  task automatic settle();
    while (pending.size() != 0 || awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_HEAP_BASE) begin
      base_reg = val;
    end else begin
      limit_reg = val;
    end
    n_cfg++;
  endtask

  // Request driver: hold a stalled request, else offer the next or idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response side: one long hold when asked, else random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (press_on && !press_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      press_done  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Monitor: predict on accepted requests, check accepted responses
  always @(posedge clk_i) begin
    ffa_req_t req;
    ffa_rsp_t ans;
    ffa_rsp_t want;
    if (rst_ni) begin
      in_took <= in_fire;
      if (in_fire) begin
        req = pending.pop_front();
        ans = serve_request(req);
        awaited_rsp.push_back(ans);
        if (req.opcode == OP_ALLOC && ans.status == RSP_OK) begin
          live_blocks.push_back('{addr: ans.result_addr, size: ans.granted_size});
        end
      end
      if (out_fire) begin
        n_rsp++;
        if (awaited_rsp.size() == 0) begin
          $error("unexpected response: addr %h size %h status %0d",
                 out_data_o.result_addr, out_data_o.granted_size, out_data_o.status);
          errs++;
        end else begin
          want = awaited_rsp.pop_front();
          if (out_data_o.result_addr !== want.result_addr) begin
            $error("result_addr: expected %h, got %h", want.result_addr,
                   out_data_o.result_addr);
            errs++;
          end
          if (out_data_o.granted_size !== want.granted_size) begin
            $error("granted_size: expected %h, got %h", want.granted_size,
                   out_data_o.granted_size);
            errs++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            errs++;
          end
        end
      end
    end
  end

  // Watchdog: abort when no handshake happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("Watchdog expired with %0d requests queued, %0d responses owed",
                 pending.size(), awaited_rsp.size());
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: rounding, oversize, null free, first-fit order, limit edge
    send_idle_pct = 31;
    recv_idle_pct = 84;
    write_reg(CFG_HEAP_BASE, 32'h0000_1000);
    write_reg(CFG_HEAP_LIMIT, 32'h0000_2000);
    offer(mk_req(OP_ALLOC, 24'd0, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd1, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd8, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd9, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
    offer(mk_req(OP_ALLOC, 24'hFF_FFF9, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'hFF_FFF8, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_FREE, 24'hFF_FFFF, 32'h0, 24'hFF_FFFF));
    offer(mk_req(OP_FREE, 24'h0, 32'hFFFF_FFFF, 24'hFF_FFFF));
    offer(mk_req(OP_FREE, SIZE_W'($urandom), 32'h0000_1008, 24'd8));
    offer(mk_req(OP_FREE, SIZE_W'($urandom), 32'h0000_2000, 24'd37));
    offer(mk_req(OP_ALLOC, 24'd30, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd8, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd100, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_FREE, SIZE_W'($urandom), 32'h0000_3000, 24'd64));
    offer(mk_req(OP_FREE, SIZE_W'($urandom), 32'h0000_3100, 24'd8));
    offer(mk_req(OP_ALLOC, 24'd24, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd1, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd4000, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd8, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd0, $urandom, SIZE_W'($urandom)));
    settle();

    // Zero limit blocks every bump; base written late has no effect
    write_reg(CFG_HEAP_LIMIT, 32'h0000_0000);
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    offer(mk_req(OP_ALLOC, 24'd5, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_FREE, SIZE_W'($urandom), 32'h0000_5000, 24'd16));
    offer(mk_req(OP_ALLOC, 24'd16, $urandom, SIZE_W'($urandom)));
    offer(mk_req(OP_ALLOC, 24'd16, $urandom, SIZE_W'($urandom)));
    settle();

    // Random traffic, sender idles lightly, receiver heavily
    write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_HEAP_BASE, 32'h0000_0000);
    run_random(120);
    settle();

    // Swap idling; fill the table past full, then tight limit traffic
    send_idle_pct = 84;
    recv_idle_pct = 31;
    write_reg(CFG_HEAP_LIMIT, heap_top + 32'h0080_0000);
    repeat (FREE_SLOTS + 2) begin
      offer(mk_req(OP_FREE, SIZE_W'($urandom), $urandom | 32'd1,
                   SIZE_W'($urandom_range(4096, 0))));
    end
    run_random(120);
    settle();

    // No idling; open with a long response hold to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    press_on = 1'b1;
    run_random(120);
    settle();

    $display("Covered %0d allocations (%0d reused, %0d out of memory), %0d frees",
             n_alloc, n_reuse, n_oom, n_free);
    $display("  (%0d table full, %0d null), %0d register writes, %0d responses checked",
             n_full, n_null, n_cfg, n_rsp);
    if (errs == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
